// ----- design/sae_pkg.sv -----
// ----------------------------------------------------------------------------
// sae_pkg
// Shared types and constants of the adaptive Sobel edge map.
// ----------------------------------------------------------------------------
`default_nettype none

package sae_pkg;

  // |Gx| and |Gy| never exceed 4*255
  localparam int unsigned GRAD_W = 11;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_MODE   = 2'd2
  } cfg_index_e;

  typedef enum logic [1:0] {
    MODE_FULL  = 2'd0,
    MODE_ABS_X = 2'd1,
    MODE_ABS_Y = 2'd2
  } grad_mode_e;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_LRD  = 13'b0000000000010,
    S_MAG  = 13'b0000000000100,
    S_SQ   = 13'b0000000001000,
    S_SQW  = 13'b0000000010000,
    S_MW   = 13'b0000000100000,
    S_BW   = 13'b0000001000000,
    S_ADV  = 13'b0000010000000,
    S_DRD  = 13'b0000100000000,
    S_DM1  = 13'b0001000000000,
    S_DM2  = 13'b0010000000000,
    S_DM3  = 13'b0100000000000,
    S_DOUT = 13'b1000000000000
  } state_e;

  typedef struct packed {
    logic start;
    logic done;
  } sqrt_ctl_t;

endpackage

`default_nettype wire

// ----- design/sae_isqrt.sv -----
// ----------------------------------------------------------------------------
// sae_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sae_isqrt import sae_pkg::*; #(
  parameter int unsigned W = 19
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [2*W-1:0] rad_i,
  output sqrt_ctl_t           ctl_o,
  output logic [W-1:0]        root_o
);

  localparam int unsigned CNT_W = $clog2(W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [2*W-1:0]   rad_q, rad_d;
  logic [W+1:0]     rem_q, rem_d;
  logic [W-1:0]     root_q, root_d;
  logic [W+1:0]     rem_sh, trial;

  assign rem_sh = {rem_q[W-1:0], rad_q[2*W-1 -: 2]};
  assign trial  = {root_q, 2'b01};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(W);
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d = rad_q << 2;
      cnt_d = cnt_q - 1'b1;
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[W-2:0], 1'b0};
      end
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign ctl_o.start = start_i;
  assign ctl_o.done  = done_q;
  assign root_o      = root_q;

endmodule

`default_nettype wire

// ----- design/sobel_adaptive_edge_map.sv -----
// ----------------------------------------------------------------------------
// sobel_adaptive_edge_map
// Sobel edge map of one luma frame with a threshold set by the mean magnitude.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o): action 0 loads the next pixel in
// raster order, action 1 drains the next edge bit once the frame is loaded.
// Loads in drain phase and drains in load phase are dropped.
// Output channel (out_valid_o / out_stall_i): one request per drain, with
// edge_res and last; after last the block is ready for a new frame.
// Config channel (cfg_valid_i / cfg_ready_o): always ready; any write to a
// known register restarts the frame. Write only while idle.
// Timing: one request at a time. A load passes S_LRD, then S_MAG and S_MW
// once a full window is present, through the bit-serial square root (S_SQ,
// S_SQW) in mode 0 only, S_BW on a border pixel, and S_ADV. A drain passes
// S_DRD, S_DM1, S_DM2 (the two partial products of the threshold compare),
// S_DM3 and S_DOUT. Both line and magnitude stores are synchronous memories.
// The output register holds a result while out_stall_i is high; the next
// request is still accepted and only waits at its own output step.
// Reset: counters, sum and window cleared, registers to 256/256/mode 1.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_adaptive_edge_map import sae_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  in_action_i,
  input  wire logic [7:0]            in_pixel_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       out_edge_res_o,
  output logic                       out_last_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);
  localparam int unsigned WW    = CW + 1;
  localparam int unsigned HW    = RW + 1;
  localparam int unsigned IDX_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int unsigned NW    = IDX_W + 1;
  localparam int unsigned MAG_W = GRAD_W + FRAC_BITS;
  localparam int unsigned SUM_W = MAG_W + IDX_W;
  localparam int unsigned PP_W  = MAG_W + NW;
  localparam int unsigned LHS_W = 2 * MAG_W + NW;
  localparam int unsigned LDEP  = 2 ** (CW + 1);
  localparam int unsigned MDEP  = MAX_WIDTH * MAX_HEIGHT;

  state_e state_q, state_d;

  logic [CFG_DATA_W-1:0] fw_q, fh_q;
  logic [1:0]            mode_q;
  logic [WW-1:0]         w_eff;
  logic [HW-1:0]         h_eff;
  logic [NW-1:0]         n_q;

  logic [CW-1:0]    col_q;
  logic [RW-1:0]    row_q;
  logic [IDX_W-1:0] pix_q;
  logic [IDX_W-1:0] drain_idx_q;
  logic             drain_phase_q;
  logic [SUM_W-1:0] sum_q;
  logic [7:0]       win_q [6];
  logic [7:0]       px_q;

  logic [7:0] line_mem [LDEP];
  logic [7:0] top_rd_q, mid_rd_q;
  logic [CW:0] top_addr, mid_addr;

  logic [MAG_W-1:0] mag_mem [MDEP];
  logic [MAG_W-1:0] mag_rd_q;
  logic             mag_we;
  logic [IDX_W-1:0] mag_waddr;
  logic [MAG_W-1:0] mag_wdata;

  logic [GRAD_W-1:0]   ax_q, ay_q;
  logic [2*GRAD_W-1:0] sq_q;
  logic [MAG_W-1:0]    mag_q;
  logic [2*MAG_W-1:0]  mag2_q;
  logic [LHS_W-1:0]    acc_q;
  logic [MAG_W-1:0]    mul_a;
  logic [PP_W-1:0]     pp;

  logic signed [12:0] gx, gy;
  logic [12:0]        gx_abs, gy_abs;

  sqrt_ctl_t        sqrt_ctl;
  logic [MAG_W-1:0] sqrt_root;

  logic out_valid_q, edge_q, last_q;

  logic in_acc, cfg_wr, restart, is_border, is_inner, fin;
  logic [WW-1:0] col_inc;
  logic [HW-1:0] row_inc;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o &&
                       (cfg_index_i == CFG_WIDTH || cfg_index_i == CFG_HEIGHT ||
                        cfg_index_i == CFG_MODE);

  always_comb begin
    if (32'(fw_q) < 32'd3)            w_eff = WW'(3);
    else if (32'(fw_q) > MAX_WIDTH)   w_eff = WW'(MAX_WIDTH);
    else                              w_eff = WW'(fw_q);
    if (32'(fh_q) < 32'd3)            h_eff = HW'(3);
    else if (32'(fh_q) > MAX_HEIGHT)  h_eff = HW'(MAX_HEIGHT);
    else                              h_eff = HW'(fh_q);
  end

  assign col_inc   = WW'(col_q) + 1'b1;
  assign row_inc   = HW'(row_q) + 1'b1;
  assign is_border = (row_q == '0) || (HW'(row_q) == h_eff - 1'b1) ||
                     (col_q == '0) || (WW'(col_q) == w_eff - 1'b1);
  assign is_inner  = (HW'(row_q) >= HW'(2)) && (WW'(col_q) >= WW'(2));
  assign fin       = (NW'(drain_idx_q) + 1'b1) >= n_q;
  assign top_addr  = {row_q[0], col_q};
  assign mid_addr  = {~row_q[0], col_q};

  always_comb begin
    gx = ($signed({5'b0, top_rd_q}) + 13'sd2 * $signed({5'b0, mid_rd_q}) +
          $signed({5'b0, px_q})) -
         ($signed({5'b0, win_q[0]}) + 13'sd2 * $signed({5'b0, win_q[2]}) +
          $signed({5'b0, win_q[4]}));
    gy = ($signed({5'b0, win_q[4]}) + 13'sd2 * $signed({5'b0, win_q[5]}) +
          $signed({5'b0, px_q})) -
         ($signed({5'b0, win_q[0]}) + 13'sd2 * $signed({5'b0, win_q[1]}) +
          $signed({5'b0, top_rd_q}));
    gx_abs = gx[12] ? 13'(-gx) : 13'(gx);
    gy_abs = gy[12] ? 13'(-gy) : 13'(gy);
  end

  assign mul_a = (state_q == S_DM1) ? mag2_q[MAG_W-1:0] : mag2_q[2*MAG_W-1:MAG_W];
  assign pp    = mul_a * n_q;

  assign mag_we    = (state_q == S_MW) || (state_q == S_BW);
  assign mag_waddr = (state_q == S_MW) ? IDX_W'(pix_q - IDX_W'(w_eff) - 1'b1) : pix_q;
  assign mag_wdata = (state_q == S_MW) ? mag_q : '0;

  assign restart = cfg_wr || (state_q == S_DOUT && !(out_valid_q && out_stall_i) && fin);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (!in_action_i && !drain_phase_q)     state_d = S_LRD;
          else if (in_action_i && drain_phase_q)  state_d = S_DRD;
        end
      end
      S_LRD: begin
        if (is_inner)       state_d = S_MAG;
        else if (is_border) state_d = S_BW;
        else                state_d = S_ADV;
      end
      S_MAG:  state_d = (mode_q == MODE_FULL) ? S_SQ : S_MW;
      S_SQ:   state_d = S_SQW;
      S_SQW:  state_d = sqrt_ctl.done ? S_MW : S_SQW;
      S_MW:   state_d = is_border ? S_BW : S_ADV;
      S_BW:   state_d = S_ADV;
      S_ADV:  state_d = S_IDLE;
      S_DRD:  state_d = S_DM1;
      S_DM1:  state_d = S_DM2;
      S_DM2:  state_d = S_DM3;
      S_DM3:  state_d = S_DOUT;
      S_DOUT: state_d = (out_valid_q && out_stall_i) ? S_DOUT : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      fw_q          <= 9'd256;
      fh_q          <= 9'd256;
      mode_q        <= MODE_ABS_X;
      n_q           <= '0;
      col_q         <= '0;
      row_q         <= '0;
      pix_q         <= '0;
      drain_idx_q   <= '0;
      drain_phase_q <= 1'b0;
      sum_q         <= '0;
      win_q         <= '{default: '0};
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= NW'(w_eff) * NW'(h_eff);
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_WIDTH:  fw_q   <= cfg_data_i;
          CFG_HEIGHT: fh_q   <= cfg_data_i;
          CFG_MODE:   mode_q <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (state_q == S_DOUT && !(out_valid_q && out_stall_i)) begin
        out_valid_q <= 1'b1;
        if (!fin) drain_idx_q <= drain_idx_q + 1'b1;
      end
      if (state_q == S_LRD) begin
        win_q[0] <= win_q[1];
        win_q[1] <= top_rd_q;
        win_q[2] <= win_q[3];
        win_q[3] <= mid_rd_q;
        win_q[4] <= win_q[5];
        win_q[5] <= px_q;
      end
      if (state_q == S_MW) sum_q <= sum_q + SUM_W'(mag_q);
      if (state_q == S_ADV) begin
        if (col_inc >= w_eff) begin
          col_q <= '0;
          if (row_inc >= h_eff) begin
            row_q         <= '0;
            pix_q         <= '0;
            drain_idx_q   <= '0;
            drain_phase_q <= 1'b1;
          end else begin
            row_q <= RW'(row_inc);
            pix_q <= pix_q + 1'b1;
          end
        end else begin
          col_q <= CW'(col_inc);
          pix_q <= pix_q + 1'b1;
        end
      end
      if (restart) begin
        col_q         <= '0;
        row_q         <= '0;
        pix_q         <= '0;
        drain_idx_q   <= '0;
        drain_phase_q <= 1'b0;
        sum_q         <= '0;
        win_q         <= '{default: '0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) px_q <= in_pixel_i;
    if (state_q == S_LRD) begin
      ax_q <= gx_abs[GRAD_W-1:0];
      ay_q <= gy_abs[GRAD_W-1:0];
    end
    if (state_q == S_MAG) begin
      sq_q <= (2*GRAD_W)'(ax_q) * (2*GRAD_W)'(ax_q) +
              (2*GRAD_W)'(ay_q) * (2*GRAD_W)'(ay_q);
      priority case (mode_q)
        MODE_ABS_X: mag_q <= MAG_W'(ax_q) << FRAC_BITS;
        MODE_ABS_Y: mag_q <= MAG_W'(ay_q) << FRAC_BITS;
        default:    mag_q <= '0;
      endcase
    end
    if (state_q == S_SQW && sqrt_ctl.done) mag_q <= sqrt_root;
    if (state_q == S_DRD) mag2_q <= (2*MAG_W)'(mag_rd_q) * (2*MAG_W)'(mag_rd_q);
    if (state_q == S_DM1) acc_q <= LHS_W'(pp);
    if (state_q == S_DM2) acc_q <= acc_q + (LHS_W'(pp) << MAG_W);
    if (state_q == S_DOUT && !(out_valid_q && out_stall_i)) begin
      edge_q <= acc_q > (LHS_W'(sum_q) << (FRAC_BITS + 2));
      last_q <= fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_LRD) line_mem[top_addr] <= px_q;
    top_rd_q <= line_mem[top_addr];
    mid_rd_q <= line_mem[mid_addr];
  end

  always_ff @(posedge clk_i) begin
    if (mag_we) mag_mem[mag_waddr] <= mag_wdata;
    mag_rd_q <= mag_mem[drain_idx_q];
  end

  sae_isqrt #(
    .W(MAG_W)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(state_q == S_SQ),
    .rad_i  ((2*MAG_W)'(sq_q) << (2 * FRAC_BITS)),
    .ctl_o  (sqrt_ctl),
    .root_o (sqrt_root)
  );

  assign out_valid_o    = out_valid_q;
  assign out_edge_res_o = edge_q;
  assign out_last_o     = last_q;

`ifndef SYNTHESIS
  a_drain_counters_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_phase_q |-> (col_q == '0 && row_q == '0 && pix_q == '0))
    else $error("position counters running in drain phase");

  a_mag_write_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mag_we |-> (NW'(mag_waddr) < n_q))
    else $error("magnitude write outside the frame");

  a_sqrt_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_ctl.done |-> (state_q == S_SQW))
    else $error("square root finished while not awaited");

  a_out_only_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRD) |-> $past(drain_phase_q))
    else $error("drain read outside drain phase");
`endif

endmodule

`default_nettype wire
